// ----- rtl/crc32acs_pkg.sv -----
// ----------------------------------------------------------------------------
// crc32acs_pkg
// Shared types, constants and CRC-32 helper functions for the CRC-32
// append/check stream block.
// ----------------------------------------------------------------------------
package crc32acs_pkg;

	localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES      = 32'hFFFFFFFF;

	localparam int          LINE_DEPTH    = 32;
	localparam int          TRAILER_BYTES = 4;
	localparam int          SEEN_W        = 6;
	localparam logic [SEEN_W-1:0] SEEN_MAX  = 6'd33;
	localparam logic [SEEN_W-1:0] TLEN_BYTE = 6'd4;
	localparam logic [SEEN_W-1:0] TLEN_BIT  = 6'd32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHECK_MODE  = 2'd0,
		REG_PACKED_MODE = 2'd1
	} reg_idx_t;

	// One queue entry: a result word, plus for a generate-mode packet end
	// the final CRC that the back end expands into the trailer.
	typedef struct packed {
		logic [7:0]  element;
		logic        has_element;
		logic        last;
		logic        good;
		logic        trailer;
		logic [31:0] crc;
	} entry_t;

	function automatic logic [31:0] crc_bit(input logic [31:0] c, input logic b);
		logic [31:0] s;
		s = c >> 1;
		if (c[0] ^ b) begin
			s = s ^ CRC_POLY_REFL;
		end
		return s;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			r = crc_bit(r, d[i]);
		end
		return r;
	endfunction

	// zero-pad to a byte boundary, then final xor
	function automatic logic [31:0] crc_finish(input logic [31:0] c, input logic [2:0] ph);
		logic [31:0] r;
		logic [2:0]  p;
		r = c;
		p = ph;
		for (int i = 0; i < 7; i++) begin
			if (p != 3'd0) begin
				r = crc_bit(r, 1'b0);
				p = p + 3'd1;
			end
		end
		return r ^ CRC_ONES;
	endfunction

endpackage

// ----- rtl/crc32acs_front.sv -----
// ----------------------------------------------------------------------------
// crc32acs_front
// Accepts words, keeps config, CRC, count and trailer delay line, and
// turns each word into at most one queue entry.
// ----------------------------------------------------------------------------
module crc32acs_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [crc32acs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crc32acs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                  acc,
	input  logic [7:0]                            element,
	input  logic                                  end_of_packet,
	output logic                                  q_push,
	output crc32acs_pkg::entry_t                  q_entry,
	output logic                                  packed_mode
);
	import crc32acs_pkg::*;

	logic              check_mode_q;
	logic              packed_mode_q;
	logic [31:0]       crc_q;
	logic [SEEN_W-1:0] seen_q;
	logic [2:0]        phase_q;
	logic [7:0]        line_q [LINE_DEPTH];

	logic [7:0]        shifted [LINE_DEPTH];
	logic [SEEN_W-1:0] tlen;
	logic [SEEN_W-1:0] seen_inc;
	logic              popped;
	logic [7:0]        old_el;
	logic [7:0]        absorb_el;
	logic [31:0]       crc_abs;
	logic [2:0]        phase_abs;
	logic [31:0]       crc_fin;
	logic              good;
	logic              do_absorb;

	assign packed_mode = packed_mode_q;
	assign tlen        = packed_mode_q ? TLEN_BYTE : TLEN_BIT;
	assign seen_inc    = (seen_q == SEEN_MAX) ? seen_q : seen_q + 6'd1;
	assign popped      = check_mode_q && (seen_q >= tlen);
	assign old_el      = packed_mode_q ? line_q[TRAILER_BYTES-1] : line_q[LINE_DEPTH-1];
	assign absorb_el   = check_mode_q ? old_el : element;
	assign do_absorb   = !check_mode_q || popped;

	always_comb begin
		shifted[0] = element;
		for (int j = 1; j < LINE_DEPTH; j++) begin
			shifted[j] = line_q[j-1];
		end
	end

	always_comb begin
		crc_abs   = crc_q;
		phase_abs = phase_q;
		if (do_absorb) begin
			if (packed_mode_q) begin
				crc_abs = crc_byte(crc_q, absorb_el);
			end else begin
				crc_abs   = crc_bit(crc_q, absorb_el[0]);
				phase_abs = phase_q + 3'd1;
			end
		end
		crc_fin = crc_finish(crc_abs, phase_abs);
	end

	// trailer compare: last word in is the top byte / bit
	always_comb begin
		good = 1'b1;
		if (packed_mode_q) begin
			for (int i = 0; i < TRAILER_BYTES; i++) begin
				if (shifted[TRAILER_BYTES-1-i] != crc_fin[8*i +: 8]) begin
					good = 1'b0;
				end
			end
		end else begin
			for (int i = 0; i < LINE_DEPTH; i++) begin
				if (shifted[LINE_DEPTH-1-i] != {7'd0, crc_fin[i]}) begin
					good = 1'b0;
				end
			end
		end
	end

	always_comb begin
		q_entry.crc         = crc_fin;
		q_entry.trailer     = 1'b0;
		q_entry.has_element = 1'b1;
		q_entry.last        = 1'b0;
		q_entry.good        = 1'b0;
		q_entry.element     = packed_mode_q ? absorb_el : {7'd0, absorb_el[0]};
		q_push              = acc;
		if (!check_mode_q) begin
			q_entry.trailer = end_of_packet;
		end else if (end_of_packet) begin
			q_entry.last = 1'b1;
			if (popped) begin
				q_entry.good = good;
			end else begin
				q_entry.has_element = 1'b0;
				q_entry.element     = 8'd0;
			end
		end else begin
			q_push = acc && popped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q  <= 1'b0;
			packed_mode_q <= 1'b1;
			crc_q         <= CRC_ONES;
			seen_q        <= '0;
			phase_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHECK_MODE: begin
					check_mode_q <= cfg_data[0];
					crc_q        <= CRC_ONES;
					seen_q       <= '0;
					phase_q      <= '0;
				end
				REG_PACKED_MODE: begin
					packed_mode_q <= cfg_data[0];
					crc_q         <= CRC_ONES;
					seen_q        <= '0;
					phase_q       <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (end_of_packet) begin
				crc_q   <= CRC_ONES;
				seen_q  <= '0;
				phase_q <= '0;
			end else begin
				crc_q   <= crc_abs;
				phase_q <= phase_abs;
				seen_q  <= seen_inc;
			end
		end
	end

	// delay line: written in check mode only, entries are read only after being written
	always_ff @(posedge clk) begin
		if (acc && check_mode_q && !cfg_we) begin
			for (int j = 0; j < LINE_DEPTH; j++) begin
				line_q[j] <= shifted[j];
			end
		end
	end

`ifndef ASSERT_OFF
	a_gen_always_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !check_mode_q |-> q_push)
		else $error("generate-mode word produced no entry");

	a_eop_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_packet && !cfg_we |=> seen_q == '0)
		else $error("packet count not cleared after end of packet");
`endif

endmodule

// ----- rtl/crc32acs_queue.sv -----
// ----------------------------------------------------------------------------
// crc32acs_queue
// Short register FIFO of entries between front and back end.
// ----------------------------------------------------------------------------
module crc32acs_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crc32acs_pkg::entry_t wdata,
	input  logic                 pop,
	output crc32acs_pkg::entry_t rdata,
	output logic                 full,
	output logic                 empty
);
	import crc32acs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("entry pushed into full queue");
`endif

endmodule

// ----- rtl/crc32acs_back.sv -----
// ----------------------------------------------------------------------------
// crc32acs_back
// Expands queue entries into result words and holds them in the output
// register.
// ----------------------------------------------------------------------------
module crc32acs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 packed_mode,
	input  crc32acs_pkg::entry_t head,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_element,
	output logic                 has_element,
	output logic                 out_last,
	output logic                 crc_good
);
	import crc32acs_pkg::*;

	logic [SEEN_W-1:0] sub_q;
	logic              ovalid_q;
	logic [7:0]        out_element_q;
	logic              has_element_q;
	logic              out_last_q;
	logic              crc_good_q;

	logic [SEEN_W-1:0] tlen;
	logic [4:0]        idx;
	logic              load;
	logic              more;
	logic [7:0]        r_element;
	logic              r_has;
	logic              r_last;
	logic              r_good;

	assign tlen  = packed_mode ? TLEN_BYTE : TLEN_BIT;
	assign idx   = 5'(sub_q - 6'd1);
	assign load  = !q_empty && (!ovalid_q || pop);
	assign more  = head.trailer && (sub_q != tlen);
	assign q_pop = load && !more;

	// sub-step 0 is the entry's own word, 1..tlen the appended CRC
	always_comb begin
		if (sub_q == '0) begin
			r_element = head.element;
			r_has     = head.has_element;
			r_last    = head.last;
			r_good    = head.good;
		end else begin
			r_element = packed_mode ? head.crc[{idx[1:0], 3'b000} +: 8]
			                        : {7'd0, head.crc[idx]};
			r_has     = 1'b1;
			r_last    = (sub_q == tlen);
			r_good    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				sub_q    <= more ? sub_q + 6'd1 : '0;
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_element_q <= r_element;
			has_element_q <= r_has;
			out_last_q    <= r_last;
			crc_good_q    <= r_good;
		end
	end

	assign empty       = !ovalid_q;
	assign out_element = out_element_q;
	assign has_element = has_element_q;
	assign out_last    = out_last_q;
	assign crc_good    = crc_good_q;

`ifndef ASSERT_OFF
	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q <= tlen)
		else $error("trailer step past trailer length");

	a_trailer_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && (sub_q == tlen) |=> out_last_q && has_element_q)
		else $error("final trailer word not marked last");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/crc32_append_or_check_stream_top.sv -----
// ----------------------------------------------------------------------------
// crc32_append_or_check_stream_top
// Reflected CRC-32 (poly 04C11DB7, init/xorout all ones) over a stream of
// bytes or bits: appends the CRC in generate mode, checks and strips it in
// check mode, flagging the packet on its last word.
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | element, end_of_packet
//  result   | pop / empty      | out_element, has_element, out_last, crc_good
//  config   | cfg_we           | cfg_index, cfg_data (0 check_mode, 1 packed_mode)
//
//  One input word per cycle while full is low. An accepted word's entry is
//  written into the queue, then loaded into the output register (empty low).
//  A generate-mode end of packet yields 1 + 4 (bytes) or 1 + 32 (bits) result
//  words; the back end emits one per cycle while the output is popped, so input
//  stalls (full) once the QUEUE_DEPTH-entry queue fills behind a trailer.
//  Reset: async, clears config (generate, packed), CRC, counters and queue;
//  the delay line needs no clearing. Mode-register writes restart the packet.
// ----------------------------------------------------------------------------
module crc32_append_or_check_stream_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [crc32acs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crc32acs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          element,
	input  logic                                end_of_packet,
	input  logic                                pop,
	output logic                                empty,
	output logic [7:0]                          out_element,
	output logic                                has_element,
	output logic                                out_last,
	output logic                                crc_good
);
	import crc32acs_pkg::*;

	logic   acc;
	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	logic   packed_mode;
	entry_t q_wdata;
	entry_t q_head;

	// an accepted word always has a free queue slot for its entry
	assign full = q_full;
	assign acc  = push && !q_full;

	crc32acs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.acc           (acc),
		.element       (element),
		.end_of_packet (end_of_packet),
		.q_push        (q_push),
		.q_entry       (q_wdata),
		.packed_mode   (packed_mode)
	);

	crc32acs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	crc32acs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.packed_mode (packed_mode),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_element (out_element),
		.has_element (has_element),
		.out_last    (out_last),
		.crc_good    (crc_good)
	);

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for crc32_append_or_check_stream_top. Streams directed
// and random packets through all four mode settings, predicts every output
// word in-line as input words are accepted, and checks each popped word.
// ----------------------------------------------------------------------------
module testbench;
	import crc32acs_pkg::*;

	// Indexes past the register map; the block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int STALL_LIMIT   = 500;  // cycles with no handshake at all
	localparam int SETTLE_CYCLES = 8;    // queue and output register drain, plus margin
	localparam int MAX_PRINTED   = 50;

	typedef struct {
		logic [7:0] el;
		logic       eop;
	} in_word_t;

	typedef struct {
		logic [7:0] el;
		logic       has;
		logic       last;
		logic       good;
	} out_word_t;

	typedef enum {FRAME_OK, FRAME_BAD_FCS, FRAME_SHORT, FRAME_OPEN} frame_kind_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  push          = 1'b0;
	logic [7:0]            element       = '0;
	logic                  end_of_packet = 1'b0;
	logic                  pop           = 1'b0;
	logic                  full;
	logic                  empty;
	logic [7:0]            out_element;
	logic                  has_element;
	logic                  out_last;
	logic                  crc_good;

	// stimulus and expectation stores
	in_word_t  item_q[$];
	out_word_t want_q[$];
	int        queued_total = 0;
	int        err_count    = 0;
	bit        idle_on      = 1'b1;
	int        gap_left     = 0;
	int        stall_left   = 0;
	int        quiet_cycles = 0;

	// predictor state: mirrors what the block holds
	logic        mode_check;
	logic        mode_packed;
	logic [31:0] crc_acc;
	logic [7:0]  hold_line [LINE_DEPTH];
	int          seen_cnt;
	logic [2:0]  bit_pos;

	crc32_append_or_check_stream_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.element       (element),
		.end_of_packet (end_of_packet),
		.pop           (pop),
		.empty         (empty),
		.out_element   (out_element),
		.has_element   (has_element),
		.out_last      (out_last),
		.crc_good      (crc_good)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// CRC arithmetic: reflected CRC-32, one bit per step, LSB first
	// ------------------------------------------------------------------------
	function automatic logic [31:0] crc_shift(input logic [31:0] c, input logic b);
		return (c[0] ^ b) ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
	endfunction

	function automatic int trailer_len();
		return mode_packed ? int'(TLEN_BYTE) : int'(TLEN_BIT);
	endfunction

	// CRC of a whole payload in the current mode; used to build good trailers
	function automatic logic [31:0] frame_fcs(input logic [7:0] pay[$]);
		logic [31:0] c;
		int          nb;
		c  = CRC_ONES;
		nb = 0;
		foreach (pay[i]) begin
			if (mode_packed) begin
				for (int k = 0; k < 8; k++) c = crc_shift(c, pay[i][k]);
			end else begin
				c = crc_shift(c, pay[i][0]);
				nb++;
			end
		end
		// bit mode: zero-pad the last partial byte
		while (nb % 8 != 0) begin
			c = crc_shift(c, 1'b0);
			nb++;
		end
		return c ^ CRC_ONES;
	endfunction

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	task automatic clear_packet_state();
		crc_acc  = CRC_ONES;
		seen_cnt = 0;
		bit_pos  = '0;
		foreach (hold_line[i]) hold_line[i] = '0;
	endtask

	task automatic absorb_element(input logic [7:0] v);
		if (mode_packed) begin
			for (int i = 0; i < 8; i++) crc_acc = crc_shift(crc_acc, v[i]);
		end else begin
			crc_acc = crc_shift(crc_acc, v[0]);
			bit_pos = bit_pos + 3'd1;
		end
	endtask

	function automatic logic [31:0] finish_fcs();
		while (bit_pos != 3'd0) begin
			crc_acc = crc_shift(crc_acc, 1'b0);
			bit_pos = bit_pos + 3'd1;
		end
		return crc_acc ^ CRC_ONES;
	endfunction

	task automatic add_word(input logic [7:0] e, input logic h, input logic l,
			input logic g);
		want_q.push_back('{e, h, l, g});
	endtask

	// Work out the result words caused by one accepted input word.
	task automatic predict_words(input logic [7:0] el, input logic eop);
		int          tlen;
		logic [7:0]  old;
		logic [7:0]  want_el;
		logic [31:0] fcs;
		logic        popped;
		logic        ok;
		tlen = trailer_len();

		if (!mode_check) begin
			// generate: pass through, CRC trails the last element
			absorb_element(el);
			add_word(mode_packed ? el : {7'd0, el[0]}, 1'b1, 1'b0, 1'b0);
			if (seen_cnt < SEEN_MAX) seen_cnt++;
			if (eop) begin
				fcs = finish_fcs();
				for (int i = 0; i < tlen; i++) begin
					want_el = mode_packed ? fcs[8*i +: 8] : {7'd0, fcs[i]};
					add_word(want_el, 1'b1, i == tlen - 1, 1'b0);
				end
				clear_packet_state();
			end
		end else begin
			// check: the last tlen elements sit in the delay line; an element
			// becomes payload as it falls out the far end
			popped = 1'b0;
			old    = '0;
			if (seen_cnt >= tlen) begin
				old = hold_line[tlen-1];
				absorb_element(old);
				if (!mode_packed) old = {7'd0, old[0]};
				popped = 1'b1;
			end
			for (int i = LINE_DEPTH - 1; i > 0; i--) hold_line[i] = hold_line[i-1];
			hold_line[0] = el;
			if (seen_cnt < SEEN_MAX) seen_cnt++;

			if (!eop) begin
				if (popped) add_word(old, 1'b1, 1'b0, 1'b0);
			end else begin
				if (popped) begin
					// trailer must match exactly, upper bits included in bit mode
					fcs = finish_fcs();
					ok  = 1'b1;
					for (int i = 0; i < tlen; i++) begin
						want_el = mode_packed ? fcs[8*i +: 8] : {7'd0, fcs[i]};
						if (hold_line[tlen-1-i] != want_el) ok = 1'b0;
					end
					add_word(old, 1'b1, 1'b1, ok);
				end else begin
					// too short for any payload: bare end marker
					add_word(8'd0, 1'b0, 1'b1, 1'b0);
				end
				clear_packet_state();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_word(input logic [7:0] el, input logic eop);
		item_q.push_back('{el, eop});
		queued_total++;
	endtask

	// One packet in the current mode. In check mode a good or bad frame gets
	// a trailer; a bad one has one trailer bit flipped (in bit mode this may
	// be an upper bit, which must also fail). A short frame is at most one
	// trailer long. An open frame has no end marker.
	task automatic queue_packet(input int n_pay, input frame_kind_t kind);
		logic [7:0]  frame[$];
		logic [31:0] fcs;
		int          tlen;
		int          k;
		tlen = trailer_len();
		if (kind == FRAME_SHORT) n_pay = $urandom_range(1, tlen);
		for (int i = 0; i < n_pay; i++) begin
			// bit mode: mostly clean 0/1, sometimes junk in the upper bits
			if (mode_packed || $urandom_range(0, 5) == 0) frame.push_back(8'($urandom));
			else frame.push_back(8'($urandom_range(0, 1)));
		end
		if (mode_check && (kind == FRAME_OK || kind == FRAME_BAD_FCS)) begin
			fcs = frame_fcs(frame);
			for (int i = 0; i < tlen; i++) begin
				frame.push_back(mode_packed ? fcs[8*i +: 8] : {7'd0, fcs[i]});
			end
			if (kind == FRAME_BAD_FCS) begin
				k = frame.size() - 1 - $urandom_range(0, tlen - 1);
				frame[k] = frame[k] ^ (8'd1 << $urandom_range(0, 7));
			end
		end
		foreach (frame[i]) begin
			queue_word(frame[i], kind != FRAME_OPEN && i == frame.size() - 1);
		end
	endtask

	// Hold the sender until every expected word is back, then let the
	// pipeline drain. Sampled on the falling edge so the driver's and
	// monitor's updates of this edge are settled.
	task automatic settle();
		do @(negedge clk);
		while (item_q.size() != 0 || push || want_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the block is idle.
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// a valid write restarts the packet; spare indexes change nothing
		if (idx == REG_CHECK_MODE) begin
			mode_check = val[0];
			clear_packet_state();
		end else if (idx == REG_PACKED_MODE) begin
			mode_packed = val[0];
			clear_packet_state();
		end
	endtask

	// Mostly well-formed frames with random content; in check mode about one
	// in ten is short and one in ten carries a bad trailer. Packed mode now
	// and then sends a long frame so the element count saturates. Sometimes
	// the phase ends inside a packet, which a later mode-register write aborts.
	task automatic random_phase(input int budget);
		int          start;
		int          r;
		frame_kind_t kind;
		start = queued_total;
		while (queued_total - start < budget) begin
			r = $urandom_range(0, 9);
			if (!mode_check) kind = FRAME_OK;
			else if (r == 0) kind = FRAME_SHORT;
			else if (r == 1) kind = FRAME_BAD_FCS;
			else kind = FRAME_OK;
			if (mode_packed) begin
				if ($urandom_range(0, 11) == 0) queue_packet($urandom_range(30, 40), kind);
				else queue_packet($urandom_range(1, 10), kind);
			end else begin
				queue_packet($urandom_range(1, 14), kind);
			end
		end
		if ($urandom_range(0, 2) == 0) queue_packet($urandom_range(1, 6), FRAME_OPEN);
		settle();
	endtask

	task automatic log_error(input string msg);
		if (err_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents queued words, predicts each one as it is accepted,
	// and inserts random gaps while idling is on.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : driver
		in_word_t nxt;
		if (arst_n) begin
			if (push && !full) predict_words(element, end_of_packet);
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (idle_on && $urandom_range(0, 6) == 0) begin
					gap_left = $urandom_range(0, 7);
					push <= 1'b0;
				end else if (item_q.size() != 0) begin
					nxt = item_q.pop_front();
					element       <= nxt.el;
					end_of_packet <= nxt.eop;
					push          <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each popped word against the oldest expectation and
	// stalls pop in random bursts while idling is on.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		out_word_t exp_w;
		if (arst_n) begin
			if (pop && !empty) begin
				if (want_q.size() == 0) begin
					log_error($sformatf("unexpected word: element %02h has %0b last %0b good %0b",
						out_element, has_element, out_last, crc_good));
				end else begin
					exp_w = want_q.pop_front();
					if (out_element !== exp_w.el)
						log_error($sformatf("out_element %02h, expected %02h",
							out_element, exp_w.el));
					if (has_element !== exp_w.has)
						log_error($sformatf("has_element %0b, expected %0b",
							has_element, exp_w.has));
					if (out_last !== exp_w.last)
						log_error($sformatf("out_last %0b, expected %0b", out_last, exp_w.last));
					if (crc_good !== exp_w.good)
						log_error($sformatf("crc_good %0b, expected %0b", crc_good, exp_w.good));
				end
			end
			if (stall_left > 0) stall_left--;
			else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
			pop <= (stall_left == 0);
		end
	end

	// Watchdog: no handshake of any kind for too long means a hang.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		// out of reset: generate mode, byte elements
		mode_check  = 1'b0;
		mode_packed = 1'b1;
		clear_packet_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// generate, bytes: extreme bytes, a one-element packet
		queue_word(8'h00, 1'b0);
		queue_word(8'hFF, 1'b1);
		queue_word(8'hA5, 1'b1);
		settle();

		// check, bytes: trailer-only frame and a single word are both short,
		// then one good and one corrupted frame
		reg_write(REG_CHECK_MODE, 1'b1);
		queue_packet(0, FRAME_OK);
		queue_word(8'h7E, 1'b1);
		queue_packet(2, FRAME_OK);
		queue_packet(2, FRAME_BAD_FCS);
		settle();

		// generate, bits: junk upper bits must be dropped, 3 bits get padded
		reg_write(REG_CHECK_MODE, 1'b0);
		reg_write(REG_PACKED_MODE, 1'b0);
		queue_word(8'hF3, 1'b0);
		queue_word(8'h02, 1'b0);
		queue_word(8'h81, 1'b1);
		// a write to a spare index mid-packet must leave the packet alone
		queue_word(8'h01, 1'b0);
		settle();
		reg_write(REG_SPARE_LO, 1'b1);
		queue_word(8'hFE, 1'b1);
		// a real write mid-packet discards what was seen so far
		queue_word(8'h00, 1'b0);
		settle();
		reg_write(REG_PACKED_MODE, 1'b0);

		// random phases across all four mode settings
		random_phase(30);
		reg_write(REG_PACKED_MODE, 1'b1);
		random_phase(40);
		reg_write(REG_CHECK_MODE, 1'b1);
		random_phase(40);
		reg_write(REG_PACKED_MODE, 1'b0);
		random_phase(70);
		reg_write(REG_SPARE_HI, 1'b0);
		reg_write(REG_PACKED_MODE, 1'b1);

		// last stretch at full rate on both sides
		idle_on = 1'b0;
		random_phase(30);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/crc32acs_pkg.sv
rtl/crc32acs_front.sv
rtl/crc32acs_queue.sv
rtl/crc32acs_back.sv
rtl/crc32_append_or_check_stream_top.sv
tb/testbench.sv
